### rtl/core/fas_pkg.sv
// ----------------------------------------------------------------------------
// fas_pkg: shared types and constants for the float32 adder/subtractor
// Stage payload structs and field widths.
// ----------------------------------------------------------------------------
package fas_pkg;

  localparam int unsigned ZERO_LZ = 26;

  typedef struct packed {
    logic        op;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_payload_t;

  typedef struct packed {
    logic [31:0] sum_bits;
  } out_payload_t;

  // after alignment
  typedef struct packed {
    logic        same_sign;
    logic        ss;
    logic [7:0]  es;
    logic [23:0] ms;
    logic [26:0] mia;
    logic        tst;
  } s1_t;

  // after add/subtract
  typedef struct packed {
    logic        ss;
    logic [7:0]  es;
    logic [27:0] mye;
  } s2_t;

  // after leading-zero count
  typedef struct packed {
    logic        ss;
    logic [7:0]  es;
    logic [27:0] mye;
    logic [4:0]  lz;
    logic        fc;
  } s3_t;

endpackage

### rtl/core/fas_stream_if.sv
// ----------------------------------------------------------------------------
// fas_stream_if: valid/ready channel
// Carries one item of parametrized payload type.
// ----------------------------------------------------------------------------
interface fas_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/fas_align.sv
// ----------------------------------------------------------------------------
// fas_align: operand swap and significand alignment
// Combinational first-stage logic: picks larger magnitude, aligns smaller.
// ----------------------------------------------------------------------------
module fas_align (
  input  logic           op,
  input  logic [31:0]    operand_a,
  input  logic [31:0]    operand_b,
  output fas_pkg::s1_t   result
);
  logic [31:0] yb;
  logic [7:0]  e1, e2, diff;
  logic [23:0] m1a, m2a, msmall;
  logic [7:0]  esmall;
  logic        a_big;
  logic [55:0] wide, shifted;

  always_comb begin
    yb = operand_b ^ {op, 31'b0};
    e1 = operand_a[30:23];
    e2 = yb[30:23];
    m1a = {1'b1, operand_a[22:0]};
    m2a = {1'b1, yb[22:0]};
    a_big = operand_a[30:0] > yb[30:0];
    diff = (e1 > e2) ? (e1 - e2) : (e2 - e1);
    msmall = a_big ? m2a : m1a;
    esmall = a_big ? e2 : e1;
    wide = (esmall == 8'd0) ? 56'd0 : {1'b0, msmall, 31'b0};
    shifted = (diff < 8'd64) ? (wide >> diff) : 56'd0;
    result.same_sign = operand_a[31] == yb[31];
    result.ss = a_big ? operand_a[31] : yb[31];
    result.es = a_big ? e1 : e2;
    result.ms = a_big ? m1a : m2a;
    result.mia = shifted[55:29];
    result.tst = |shifted[28:0];
  end
endmodule

### rtl/core/fas_norm.sv
// ----------------------------------------------------------------------------
// fas_norm: normalize and round
// Combinational last-stage logic: shift by leading zeros, round, pack.
// ----------------------------------------------------------------------------
module fas_norm (
  input  fas_pkg::s3_t  s,
  output logic [31:0]   sum_bits
);
  logic [1:0]  lzlo;
  logic [2:0]  lzhi;
  logic [27:0] myf, my;
  logic [4:0]  low5;
  logic        gb;
  logic [7:0]  eyd, eye, eyr;
  logic [8:0]  eyf, eyfi;

  always_comb begin
    lzlo = s.lz[1:0];
    lzhi = s.lz[4:2];
    myf = s.mye << lzlo;
    low5 = s.mye[4:0];
    case (lzlo)
      2'd0: gb = low5[3] & (low5[4] | (|low5[2:0]));
      2'd1: gb = low5[2] & (low5[3] | (|low5[1:0]));
      2'd2: gb = low5[1] & (low5[2] | low5[0]);
      default: gb = low5[0] & low5[1];
    endcase
    eyd = s.fc ? (s.es + 8'd1) : s.es;
    if (lzhi == 3'd0) begin
      my = myf + {23'd0, gb, 4'd0};
      eye = eyd;
    end else begin
      my = myf << {lzhi, 2'b00};
      eye = s.es;
    end
    eyf = {1'b0, eye} - {4'd0, s.lz};
    eyfi = eyf + 9'd1;
    if (eyfi[8] || s.lz == 5'(fas_pkg::ZERO_LZ)) eyr = 8'd0;
    else eyr = eyfi[7:0];
    sum_bits = {s.ss, eyr, my[26:4]};
  end
endmodule

### rtl/core/float32_add_sub.sv
// ----------------------------------------------------------------------------
// float32_add_sub: single-precision adder/subtractor
// Throughput one item per cycle while the output is taken.
// Stages: align, add, leading-zero count, normalize/round into output register.
// The whole pipeline stalls together when the output is not taken.
// Synchronous reset clears all stage valid bits; no state links items.
// ----------------------------------------------------------------------------
module float32_add_sub (
  input  logic  clk,
  input  logic  rst,
  fas_stream_if.sink   in_if,
  fas_stream_if.source out_if
);
  logic         v1, v2, v3, v4;
  fas_pkg::s1_t s1, s1_next;
  fas_pkg::s2_t s2;
  fas_pkg::s3_t s3;
  logic [31:0]  res_next, res;
  logic         advance;
  logic [27:0]  sum;
  logic [4:0]   lz;

  assign advance = !v4 || out_if.ready;
  assign in_if.ready = advance && !rst;
  assign out_if.valid = v4;
  assign out_if.data.sum_bits = res;

  fas_align u_align (
    .op(in_if.data.op), .operand_a(in_if.data.operand_a),
    .operand_b(in_if.data.operand_b), .result(s1_next));

  always_comb begin
    if (s1.same_sign)
      sum = {1'b0, s1.ms, 3'b0} + {s1.mia, s1.tst};
    else
      sum = {1'b0, s1.ms, 3'b0} - {s1.mia, s1.tst};
  end

  // priority count over the 26 upper bits
  always_comb begin
    lz = 5'(fas_pkg::ZERO_LZ);
    for (int i = 0; i < 26; i++)
      if (s2.mye[2 + i]) lz = 5'(25 - i);
  end

  fas_norm u_norm (.s(s3), .sum_bits(res_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (advance) begin
      v1 <= in_if.valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
    if (advance) begin
      s1 <= s1_next;
      s2.ss <= s1.ss;
      s2.es <= s1.es;
      s2.mye <= sum;
      s3.ss <= s2.ss;
      s3.es <= s2.es;
      s3.mye <= s2.mye;
      s3.lz <= lz;
      s3.fc <= (s2.mye[25:2] == 24'hffffff) && !s2.mye[27] &&
               (s2.mye[26] || s2.mye[1]);
      res <= res_next;
    end
  end
endmodule

### tb/tb_float32_add_sub.sv
// ----------------------------------------------------------------------------
// tb_float32_add_sub: self-checking testbench for the float32 adder/subtractor
// Directed operand table followed by random operand pairs aimed at rounding,
// cancellation, flushed and wrapping exponents, with add and subtract mixed.
// Each accepted item is scored against its table sum or an in-bench model
// of the datapath, under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_float32_add_sub;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;

  fas_stream_if #(.payload_t(fas_pkg::in_payload_t))  in_if ();
  fas_stream_if #(.payload_t(fas_pkg::out_payload_t)) out_if ();

  float32_add_sub i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_if  (in_if),
    .out_if (out_if)
  );

  typedef struct {
    logic        op;
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    logic [31:0] sum;
  } vec_t;

  logic [31:0] pending_sums[$];
  int          error_count;
  int          send_idle;
  int          recv_stall;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Align, add, count leading zeros, normalize and round, as the datapath does.
  function automatic logic [31:0] fp_sum(input logic op, input logic [31:0] xa,
                                         input logic [31:0] operand_b);
    logic [31:0] yb;
    logic [7:0]  e1, e2, diff, es, eyd, eye, eyr;
    logic [23:0] m1a, m2a, ms;
    logic [55:0] m1c, m2c, small_c;
    logic [26:0] mia;
    logic        tst, ss, fc, gb;
    logic [63:0] wide;
    logic [27:0] mye;
    logic [4:0]  lz, low5;
    logic [1:0]  lzlo;
    logic [2:0]  lzhi;
    logic [31:0] myf, my;
    logic [8:0]  eyf, eyfi;
    yb   = operand_b ^ {op, 31'd0};
    e1   = xa[30:23];
    e2   = yb[30:23];
    m1a  = {1'b1, xa[22:0]};
    m2a  = {1'b1, yb[22:0]};
    diff = (e1 > e2) ? e1 - e2 : e2 - e1;
    m1c  = (e1 == 8'd0) ? 56'd0 : {1'b0, m1a, 31'd0};
    m2c  = (e2 == 8'd0) ? 56'd0 : {1'b0, m2a, 31'd0};
    m1c  = (diff < 64) ? m1c >> diff : 56'd0;
    m2c  = (diff < 64) ? m2c >> diff : 56'd0;
    if (xa[30:0] > yb[30:0]) begin
      ms = m1a; small_c = m2c; es = e1; ss = xa[31];
    end else begin
      ms = m2a; small_c = m1c; es = e2; ss = yb[31];
    end
    mia = small_c[55:29];
    tst = |small_c[28:0];
    if (xa[31] == yb[31])
      wide = ({40'd0, ms} << 3) + ({37'd0, mia} << 1) + {63'd0, tst};
    else
      wide = ({40'd0, ms} << 3) - (({37'd0, mia} << 1) + {63'd0, tst});
    mye = wide[27:0];
    lz = 5'(fas_pkg::ZERO_LZ);
    for (int i = 25; i >= 0; i--) begin
      if (mye[i + 2]) begin
        lz = 5'(25 - i);
        break;
      end
    end
    fc   = (mye[25:2] == 24'hffffff) && !mye[27] && (mye[26] || mye[1]);
    lzlo = lz[1:0];
    lzhi = lz[4:2];
    myf  = {4'd0, mye} << lzlo;
    low5 = mye[4:0];
    case (lzlo)
      2'd0: gb = low5[3] && (low5[4] || (low5[2:0] != 0));
      2'd1: gb = low5[2] && (low5[3] || (low5[1:0] != 0));
      2'd2: gb = low5[1] && (low5[2] || low5[0]);
      default: gb = low5[0] && low5[1];
    endcase
    eyd = fc ? es + 8'd1 : es;
    if (lzhi == 3'd0) begin
      my  = (myf + {27'd0, gb, 4'd0}) & 32'hfffffff;
      eye = eyd;
    end else begin
      my  = (myf << {lzhi, 2'b00}) & 32'hfffffff;
      eye = es;
    end
    eyf  = {1'b0, eye} - {4'd0, lz};
    eyfi = eyf + 9'd1;
    eyr  = (eyfi[8] || lz == 5'(fas_pkg::ZERO_LZ)) ? 8'd0 : eyfi[7:0];
    return {ss, eyr, my[26:4]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: sum_bits got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Hold valid until the item is taken; idle first at the current sender rate.
  task automatic send_pair(input logic op, input logic [31:0] a, input logic [31:0] b,
                           input logic known, input logic [31:0] sum);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{op: op, operand_a: a, operand_b: b};
    do @(posedge clk); while (!in_if.ready);
    pending_sums.push_back(known ? sum : fp_sum(op, a, b));
  endtask

  function automatic logic [31:0] rand_operand(input logic [31:0] ref_op);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1, 2: ;
      3, 4: v[30:23] = ref_op[30:23] + 8'($urandom_range(6)) - 8'd3;
      5: v = ref_op ^ 32'h80000000 ^ ($urandom_range(1) ? 32'h1 << $urandom_range(22) : 0);
      6: v[30:23] = 8'd0;
      7: v[30:23] = $urandom_range(1) ? 8'hff : 8'hfe;
      8: v[22:0] = $urandom_range(1) ? 23'h7fffff : 23'h0;
      default: v[30:23] = ref_op[30:23] + 8'($urandom_range(40)) - 8'd20;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst)
      out_if.ready <= 1'b0;
    else
      out_if.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_sums.size() == 0)
        report_mismatch("unexpected item", out_if.data.sum_bits, 32'hx);
      else if (out_if.data.sum_bits !== pending_sums[0])
        report_mismatch("wrong sum", out_if.data.sum_bits, pending_sums.pop_front());
      else
        void'(pending_sums.pop_front());
    end
  end

  initial begin
    #(4_000_000ns);
    $display("Verification failed");
    $finish;
  end

  initial begin
    vec_t        directed[$];
    logic [31:0] a;
    logic        op;
    int          wait_cycles;
    directed = '{
      '{1'b0, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
      '{1'b0, 32'h3f800000, 32'h3f800000, 1'b1, 32'h40000000},
      '{1'b0, 32'h3f800000, 32'hbf800000, 1'b1, 32'h80000000},
      '{1'b1, 32'h3f800000, 32'h3f800000, 1'b1, 32'h80000000},
      '{1'b0, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0},
      '{1'b1, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0},
      '{1'b0, 32'h7fffffff, 32'h00000001, 1'b0, 32'h0},
      '{1'b0, 32'h7f7fffff, 32'h7f7fffff, 1'b0, 32'h0},
      '{1'b0, 32'h7f800000, 32'h3f800000, 1'b0, 32'h0},
      '{1'b0, 32'h00800000, 32'h80800001, 1'b0, 32'h0},
      '{1'b1, 32'h00800000, 32'h00800001, 1'b0, 32'h0},
      '{1'b0, 32'h00000001, 32'h3f800000, 1'b0, 32'h0},
      '{1'b0, 32'h3f800000, 32'h007fffff, 1'b0, 32'h0},
      '{1'b0, 32'h3f800000, 32'h33800000, 1'b0, 32'h0},
      '{1'b0, 32'h3f800000, 32'h33800001, 1'b0, 32'h0},
      '{1'b0, 32'h3f800001, 32'h33800000, 1'b0, 32'h0},
      '{1'b0, 32'h3fffffff, 32'h34000000, 1'b0, 32'h0},
      '{1'b0, 32'h3f800000, 32'hb3800000, 1'b0, 32'h0},
      '{1'b1, 32'h3f800000, 32'h3f7fffff, 1'b0, 32'h0},
      '{1'b0, 32'h4b7fffff, 32'h3f000000, 1'b0, 32'h0},
      '{1'b0, 32'h7f000000, 32'h00800000, 1'b0, 32'h0},
      '{1'b0, 32'h80000000, 32'h00000000, 1'b0, 32'h0},
      '{1'b0, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0},
      '{1'b1, 32'h55555555, 32'h2aaaaaaa, 1'b0, 32'h0}
    };
    error_count = 0;
    send_idle   = 0;
    recv_stall  = 0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_pair(directed[i].op, directed[i].a, directed[i].b, directed[i].known,
                directed[i].sum);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle  = (phase == 1) ? 75 : (phase == 3) ? 16 : 0;
      recv_stall = (phase == 2) ? 75 : (phase == 3) ? 16 : 0;
      for (int n = 0; n < 458; n++) begin
        a = $urandom;
        op = 1'($urandom_range(1));
        if ($urandom_range(3) == 0) a[30:23] = $urandom_range(1) ? 8'd0 : 8'hff;
        send_pair(op, a, rand_operand(a), 1'b0, 32'h0);
      end
      if (phase == 1) begin
        // drain the pipeline before going on
        in_if.valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge clk);
      end
    end

    in_if.valid <= 1'b0;
    wait_cycles = 0;
    while (pending_sums.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_sums.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### float32_add_sub.f
rtl/core/fas_pkg.sv
rtl/core/fas_stream_if.sv
rtl/core/fas_align.sv
rtl/core/fas_norm.sv
rtl/core/float32_add_sub.sv
tb/tb_float32_add_sub.sv
